[src/two_beam_occupancy_counter_macros.svh]
// Assertion macros for the two-beam occupancy counter.
`ifndef TWO_BEAM_OCCUPANCY_COUNTER_MACROS_SVH
`define TWO_BEAM_OCCUPANCY_COUNTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define OBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("occupancy counter check failed");

// Next-cycle implication, checked out of reset.
`define OBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("occupancy counter check failed");

`endif

[src/obc_pkg.sv]
// Types, codes and reset values shared by the occupancy counter modules.
`default_nettype none

package obc_pkg;

   localparam int DEFAULT_COUNT_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int REG_WIDTH           = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_CAPACITY  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT_TICKS = 2'd1;

   localparam logic [REG_WIDTH-1:0] MAX_CAPACITY_RESET  = 16'd10;
   localparam logic [REG_WIDTH-1:0] TIMEOUT_TICKS_RESET = 16'd31;
   localparam logic [REG_WIDTH-1:0] TICK_MAX            = 16'hFFFF;
   localparam logic [15:0]          OCC_MAX             = 16'hFFFF;

   localparam logic OP_SENSOR = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [1:0] STATUS_EMPTY    = 2'd0;
   localparam logic [1:0] STATUS_OCCUPIED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_ENTRY = 2'd1,
      PHASE_EXIT  = 2'd2
   } phase_type;

   typedef struct packed {
      logic opcode;
      logic inner_beam;
      logic outer_beam;
   } req_type;

   typedef struct packed {
      logic [15:0] occupancy;
      logic [1:0]  room_status;
      logic        light_on;
      logic [1:0]  phase;
   } rsp_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] max_capacity;
      logic [REG_WIDTH-1:0] timeout_ticks;
   } cfg_type;

endpackage

`default_nettype wire

[src/obc_csr.sv]
// Configuration registers: capacity and timeout.
`default_nettype none

module obc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [obc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [obc_pkg::REG_WIDTH-1:0]       csr_data,
   output      obc_pkg::cfg_type                    cfg
);
   import obc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_CAPACITY:  cfg_in.max_capacity  = csr_data;
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_capacity  <= MAX_CAPACITY_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[src/obc_step.sv]
// Sequence state, people and tick counters, and the per-beat result logic.
`default_nettype none

module obc_step #(
   parameter int COUNT_WIDTH = obc_pkg::DEFAULT_COUNT_WIDTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire obc_pkg::req_type item,
   input  wire obc_pkg::cfg_type cfg,
   output      obc_pkg::rsp_type result
);
   import obc_pkg::*;

   localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   phase_type              phase_ff;
   phase_type              phase_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [REG_WIDTH-1:0]   tick_ff;
   logic [REG_WIDTH-1:0]   tick_in;
   logic [CMP_WIDTH-1:0]   count_ext;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      tick_in  = tick_ff;
      if (item.opcode == OP_SENSOR) begin
         case (phase_ff)
            PHASE_ENTRY: begin
               if (item.outer_beam) begin
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + COUNT_WIDTH'(1);
                  end
                  phase_in = PHASE_IDLE;
               end
            end
            PHASE_EXIT: begin
               if (item.inner_beam) begin
                  if (count_ff != '0) begin
                     count_in = count_ff - COUNT_WIDTH'(1);
                  end
                  phase_in = PHASE_IDLE;
               end
            end
            default: begin
               phase_in = PHASE_IDLE;
               if (item.inner_beam) begin
                  phase_in = PHASE_ENTRY;
                  tick_in  = '0;
               end
               if (item.outer_beam) begin
                  phase_in = PHASE_EXIT;
                  tick_in  = '0;
               end
            end
         endcase
      end else if (tick_ff != TICK_MAX) begin
         tick_in = tick_ff + REG_WIDTH'(1);
      end

      // drop an unfinished sequence once the timeout is reached
      if (phase_in != PHASE_IDLE && tick_in >= cfg.timeout_ticks) begin
         phase_in = PHASE_IDLE;
         tick_in  = '0;
      end
   end

   always_comb begin
      count_ext        = CMP_WIDTH'(count_in);
      result.occupancy = (count_ext > CMP_WIDTH'(OCC_MAX)) ? OCC_MAX : count_ext[15:0];
      result.light_on  = (count_in != '0);
      result.phase     = phase_in;
      if (count_in == '0) begin
         result.room_status = STATUS_EMPTY;
      end else if (count_ext >= CMP_WIDTH'(cfg.max_capacity)) begin
         result.room_status = STATUS_FULL;
      end else begin
         result.room_status = STATUS_OCCUPIED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         count_ff <= '0;
         tick_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

`default_nettype wire

[src/two_beam_occupancy_counter.sv]
// Top level of the two-beam occupancy counter.
//
// req_ channel: one beat per sensor change (opcode 0, with both beam levels)
// or timer tick (opcode 1). rsp_ channel: one beat per request beat, carrying
// occupancy, room status, light drive and the sequence phase after the beat.
// csr_ channel: register writes (0 max_capacity, 1 timeout_ticks), always
// ready, to be issued only while no request is in flight.
// An accepted request passes through the input register, then the result
// register. Throughput: one beat per cycle while the receiver does not stall;
// the counter update between the two registers sets that figure.
// When the receiver stalls, the result register holds and the input register
// takes one more beat; req_ready then drops until the result is taken.
// Reset: synchronous; clears the phase to idle, both counters to zero, both
// pipeline stages to empty, and loads capacity 10 and timeout 31.
`default_nettype none
`include "two_beam_occupancy_counter_macros.svh"

module two_beam_occupancy_counter #(
   parameter int COUNT_WIDTH = obc_pkg::DEFAULT_COUNT_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire obc_pkg::req_type                    req_data,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      obc_pkg::rsp_type                    rsp_data,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [obc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [obc_pkg::REG_WIDTH-1:0]       csr_data
);
   import obc_pkg::*;

   cfg_type cfg;
   req_type item_ff;
   logic    item_valid_ff;
   logic    item_valid_in;
   rsp_type result;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    advance;
   logic    req_beat;

   obc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   obc_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign req_beat  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_beat) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   `OBC_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_ready, item_valid_ff && rsp_valid_ff && !rsp_ready)
   `OBC_ASSERT_NEXT(a_empty_pipe_latency, clock, reset, req_beat && !item_valid_ff && !rsp_valid_ff, advance ##1 rsp_valid)
   `OBC_ASSERT_NOW(a_light_matches_count, clock, reset, rsp_valid, rsp_data.light_on == (rsp_data.occupancy != 16'd0))
   `OBC_ASSERT_NOW(a_empty_status, clock, reset, rsp_valid, (rsp_data.room_status == STATUS_EMPTY) == (rsp_data.occupancy == 16'd0))

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the two-beam occupancy counter.
`timescale 1ns / 1ps

import obc_pkg::*;

class occupancy_tracker;
   logic [REG_WIDTH-1:0] capacity;
   logic [REG_WIDTH-1:0] timeout;
   phase_type            seq_phase;
   logic [15:0]          people;
   logic [15:0]          ticks;
   rsp_type              pending_reports[$];
   int                   mismatches;
   int                   checked;

   function new();
      capacity   = MAX_CAPACITY_RESET;
      timeout    = TIMEOUT_TICKS_RESET;
      seq_phase  = PHASE_IDLE;
      people     = '0;
      ticks      = '0;
      mismatches = 0;
      checked    = 0;
   endfunction

   function void write_register(logic [CSR_INDEX_WIDTH-1:0] index, logic [REG_WIDTH-1:0] value);
      case (index)
         CSR_MAX_CAPACITY: begin
            capacity = value;
         end
         CSR_TIMEOUT_TICKS: begin
            timeout = value;
         end
         default: begin
         end
      endcase
   endfunction

   function void note_request(req_type beat);
      rsp_type report;
      if (beat.opcode == OP_SENSOR) begin
         case (seq_phase)
            PHASE_ENTRY: begin
               if (beat.outer_beam) begin
                  if (people != 16'hFFFF) people++;
                  seq_phase = PHASE_IDLE;
               end
            end
            PHASE_EXIT: begin
               if (beat.inner_beam) begin
                  if (people != 16'd0) people--;
                  seq_phase = PHASE_IDLE;
               end
            end
            default: begin
               seq_phase = PHASE_IDLE;
               if (beat.inner_beam) begin
                  seq_phase = PHASE_ENTRY;
                  ticks     = '0;
               end
               if (beat.outer_beam) begin
                  seq_phase = PHASE_EXIT;
                  ticks     = '0;
               end
            end
         endcase
      end else if (ticks != TICK_MAX) begin
         ticks++;
      end
      if (seq_phase != PHASE_IDLE && ticks >= timeout) begin
         seq_phase = PHASE_IDLE;
         ticks     = '0;
      end
      report.occupancy = people;
      if (people == 16'd0) report.room_status = STATUS_EMPTY;
      else if (people >= capacity) report.room_status = STATUS_FULL;
      else report.room_status = STATUS_OCCUPIED;
      report.light_on = (people != 16'd0);
      report.phase    = seq_phase;
      pending_reports.push_back(report);
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (pending_reports.size() == 0) begin
         $error("result beat with no request outstanding: %p", got);
         mismatches++;
         return;
      end
      want = pending_reports.pop_front();
      checked++;
      if (got.occupancy !== want.occupancy) begin
         $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
         mismatches++;
      end
      if (got.room_status !== want.room_status) begin
         $error("room_status: expected %0d, got %0d", want.room_status, got.room_status);
         mismatches++;
      end
      if (got.light_on !== want.light_on) begin
         $error("light_on: expected %0d, got %0d", want.light_on, got.light_on);
         mismatches++;
      end
      if (got.phase !== want.phase) begin
         $error("phase: expected %0d, got %0d", want.phase, got.phase);
         mismatches++;
      end
   endfunction

   function int outstanding();
      return pending_reports.size();
   endfunction
endclass

module tb;
   localparam int STALL_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 4;
   localparam int RANDOM_PHASE  = 200;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [REG_WIDTH-1:0]       csr_data  = '0;

   occupancy_tracker tracker = new();
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               beats_sent    = 0;
   int               csr_writes    = 0;
   int               stalled       = 0;

   two_beam_occupancy_counter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            tracker.write_register(csr_index, csr_data);
            csr_writes++;
         end
         if (req_valid && req_ready) tracker.note_request(req_data);
         if (rsp_valid && rsp_ready) tracker.check_result(rsp_data);
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
         if (stalled >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // call at the falling edge; returns at the falling edge after the beat
   task automatic send_req(logic opcode, logic inner, logic outer);
      req_type beat;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      beat.opcode     = opcode;
      beat.inner_beam = inner;
      beat.outer_beam = outer;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index, logic [REG_WIDTH-1:0] value);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   // mostly complete entry or exit sequences, with noise and aborted ones
   task automatic random_burst();
      int pick;
      int extra;
      pick  = $urandom_range(99);
      extra = $urandom_range(3);
      if (pick < 40) begin
         send_req(OP_SENSOR, 1'b1, 1'b0);
         repeat (extra) begin
            if (coin()) send_req(OP_TICK, coin(), coin());
            else send_req(OP_SENSOR, coin(), 1'b0);
         end
         send_req(OP_SENSOR, coin(), 1'b1);
      end else if (pick < 70) begin
         send_req(OP_SENSOR, coin(), 1'b1);
         repeat (extra) begin
            if (coin()) send_req(OP_TICK, coin(), coin());
            else send_req(OP_SENSOR, 1'b0, coin());
         end
         send_req(OP_SENSOR, 1'b1, coin());
      end else if (pick < 85) begin
         send_req(OP_TICK, coin(), coin());
      end else begin
         send_req(OP_SENSOR, coin(), coin());
      end
   endtask

   task automatic random_phase(int beats, int send_pct, int recv_pct);
      int target;
      target        = beats_sent + beats;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (beats_sent < target) random_burst();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 14;
      recv_idle_pct = 60;
      send_req(OP_SENSOR, 1'b0, 1'b0);
      send_req(OP_TICK, 1'b1, 1'b1);
      send_req(OP_SENSOR, 1'b1, 1'b0);
      send_req(OP_SENSOR, 1'b1, 1'b0);
      send_req(OP_TICK, 1'b0, 1'b1);
      send_req(OP_SENSOR, 1'b0, 1'b1);
      send_req(OP_SENSOR, 1'b0, 1'b1);
      send_req(OP_SENSOR, 1'b0, 1'b0);
      send_req(OP_SENSOR, 1'b1, 1'b0);
      send_req(OP_SENSOR, 1'b1, 1'b1);
      send_req(OP_SENSOR, 1'b1, 1'b1);
      write_csr(CSR_MAX_CAPACITY, 16'd0);
      write_csr(CSR_TIMEOUT_TICKS, 16'd0);
      send_req(OP_SENSOR, 1'b1, 1'b0);
      send_req(OP_SENSOR, 1'b0, 1'b1);
      write_csr(CSR_MAX_CAPACITY, 16'd1);
      write_csr(CSR_TIMEOUT_TICKS, 16'd2);
      send_req(OP_SENSOR, 1'b1, 1'b0);
      send_req(OP_TICK, 1'b0, 1'b0);
      send_req(OP_TICK, 1'b1, 1'b0);
      send_req(OP_SENSOR, 1'b0, 1'b1);
      send_req(OP_SENSOR, 1'b1, 1'b1);
      send_req(OP_SENSOR, 1'b1, 1'b0);
      send_req(OP_SENSOR, 1'b0, 1'b1);
      send_req(OP_SENSOR, 1'b1, 1'b0);
      send_req(OP_SENSOR, 1'b1, 1'b1);

      write_csr(CSR_MAX_CAPACITY, 16'd3);
      write_csr(CSR_TIMEOUT_TICKS, 16'd2);
      random_phase(RANDOM_PHASE, 14, 60);
      write_csr(CSR_MAX_CAPACITY, 16'($urandom_range(1, 8)));
      write_csr(CSR_TIMEOUT_TICKS, 16'($urandom_range(1, 4)));
      random_phase(RANDOM_PHASE, 60, 14);
      write_csr(CSR_MAX_CAPACITY, 16'd0);
      write_csr(CSR_TIMEOUT_TICKS, 16'hFFFF);
      random_phase(RANDOM_PHASE, 0, 0);

      // capacity at both extremes
      write_csr(CSR_MAX_CAPACITY, 16'hFFFF);
      send_req(OP_SENSOR, 1'b1, 1'b0);
      send_req(OP_SENSOR, 1'b0, 1'b1);
      send_req(OP_SENSOR, 1'b1, 1'b0);
      write_csr(CSR_MAX_CAPACITY, 16'd0);
      send_req(OP_TICK, 1'b1, 1'b1);
      send_req(OP_SENSOR, 1'b0, 1'b1);
      send_req(OP_SENSOR, 1'b1, 1'b1);

      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d request beats, checked %0d results, made %0d register writes.",
               beats_sent, tracker.checked, csr_writes);
      $display("Covered empty, occupied and full status, capacity and timeout extremes, and stalls.");
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
